/* sv/ldos_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ldos_pkg
// shared types, constants and codes for the lorentzian density of states unit
// ----------------------------------------------------------------------------
package ldos_pkg;

  localparam int unsigned MaxStates = 256;
  localparam int unsigned IdxW      = $clog2(MaxStates);
  localparam int unsigned CntW      = IdxW + 1;

  localparam logic [31:0] TwoPiQ29   = 32'd3373259426;
  localparam logic [47:0] DensMax    = 48'hFFFF_FFFF_FFFF;
  localparam logic [30:0] EnergyMax  = 31'h7FFF_FFFF;

  typedef enum logic [1:0] {
    CFG_WIDTH = 2'd0,
    CFG_STEP  = 2'd1,
    CFG_COUNT = 2'd2
  } cfg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_GRID,
    ST_READ,
    ST_DIFF,
    ST_SQ_LO,
    ST_SQ_HI,
    ST_PI_LO,
    ST_PI_HI,
    ST_DEN,
    ST_DIV,
    ST_ACC,
    ST_OUT
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic load_entry;
    logic start_grid;
    logic read_entry;
    logic calc_diff;
    logic sq_lo;
    logic sq_hi;
    logic pi_lo;
    logic pi_hi;
    logic calc_den;
    logic div_start;
    logic div_step;
    logic accumulate;
    logic clear_sum;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic div_done;
  } dp_status_t;

endpackage

/* sv/ldos_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ldos channel interfaces
// valid/ready channels for requests, results and register writes
// ----------------------------------------------------------------------------
interface ldos_req_if;
  logic        valid;
  logic        ready;
  logic        req_type;
  logic [7:0]  entry_index;
  logic [31:0] state_energy;
  logic [31:0] state_rate;
  logic [19:0] grid_index;
  modport source (output valid, req_type, entry_index, state_energy, state_rate,
                  grid_index, input ready);
  modport sink (input valid, req_type, entry_index, state_energy, state_rate,
                grid_index, output ready);
endinterface

interface ldos_res_if;
  logic        valid;
  logic        ready;
  logic [30:0] grid_energy;
  logic [47:0] density;
  modport source (output valid, grid_energy, density, input ready);
  modport sink (input valid, grid_energy, density, output ready);
endinterface

interface ldos_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

/* sv/ldos_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ldos_ctrl
// sequencer: takes table loads and walks the entries of one evaluation through the datapath
// ----------------------------------------------------------------------------
module ldos_ctrl import ldos_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             in_type_i,
  output logic             in_ready_o,
  input  logic [CntW-1:0]  count_i,
  output logic [IdxW-1:0]  entry_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  input  dp_status_t       status_i,
  output dp_cmd_t          cmd_o
);

  state_e          state_q, state_d;
  logic [CntW-1:0] k_q, k_d, n_q, n_d;
  logic            out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      k_q         <= '0;
      n_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      k_q         <= k_d;
      n_q         <= n_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign entry_o     = k_q[IdxW-1:0];
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d     = state_q;
    k_d         = k_q;
    n_d         = n_q;
    out_valid_d = out_valid_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    if (out_valid_q && out_ready_i) out_valid_d = 1'b0;
    case (state_q)
      ST_IDLE: begin
        // hold off while the last result still waits, its payload must not move
        in_ready_o = !out_valid_q;
        if (in_valid_i && !out_valid_q) begin
          if (!in_type_i) begin
            cmd_o.load_entry = 1'b1;
          end else begin
            cmd_o.start_grid = 1'b1;
            cmd_o.clear_sum  = 1'b1;
            k_d     = '0;
            n_d     = (count_i > CntW'(MaxStates)) ? CntW'(MaxStates) : count_i;
            state_d = ST_GRID;
          end
        end
      end
      ST_GRID: state_d = (n_q == '0) ? ST_OUT : ST_READ;
      ST_READ: begin
        cmd_o.read_entry = 1'b1;
        state_d = ST_DIFF;
      end
      ST_DIFF: begin
        cmd_o.calc_diff = 1'b1;
        state_d = ST_SQ_LO;
      end
      ST_SQ_LO: begin
        cmd_o.sq_lo = 1'b1;
        state_d = ST_SQ_HI;
      end
      ST_SQ_HI: begin
        cmd_o.sq_hi = 1'b1;
        state_d = ST_PI_LO;
      end
      ST_PI_LO: begin
        cmd_o.pi_lo = 1'b1;
        state_d = ST_PI_HI;
      end
      ST_PI_HI: begin
        cmd_o.pi_hi = 1'b1;
        state_d = ST_DEN;
      end
      ST_DEN: begin
        cmd_o.calc_den = 1'b1;
        state_d = ST_DIV;
      end
      ST_DIV: begin
        if (status_i.div_done) begin
          state_d = ST_ACC;
        end else begin
          cmd_o.div_step = 1'b1;
        end
      end
      ST_ACC: begin
        cmd_o.accumulate = 1'b1;
        k_d = k_q + 1'b1;
        state_d = (k_q + 1'b1 == n_q) ? ST_OUT : ST_READ;
      end
      ST_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
    cmd_o.div_start = cmd_o.calc_den;
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE && state_q != ST_GRID) |-> k_q <= n_q)
    else $error("entry counter past count");
  a_res_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_OUT && state_d == ST_IDLE) |=> out_valid_q)
    else $error("result not raised");
  a_busy_no_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> !in_ready_o)
    else $error("accept while busy");

endmodule

/* sv/ldos_dp.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ldos_dp
// datapath: state tables, staged multiplies, serial divider, accumulator
// ----------------------------------------------------------------------------
module ldos_dp import ldos_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  dp_cmd_t          cmd_i,
  output dp_status_t       status_o,
  input  logic [7:0]       load_idx_i,
  input  logic [31:0]      load_energy_i,
  input  logic [31:0]      load_rate_i,
  input  logic [19:0]      grid_index_i,
  input  logic [IdxW-1:0]  entry_i,
  input  logic [30:0]      width_i,
  input  logic [24:0]      step_i,
  output logic [30:0]      grid_energy_o,
  output logic [47:0]      density_o
);

  logic [63:0] mem_q [MaxStates];
  logic [63:0] rd_q;
  logic [30:0] e_q;
  logic [32:0] ad_q;
  logic [65:0] sq_q;
  logic [63:0] pi_q;
  logic        pi_sat_q;
  logic [63:0] den_q;
  logic [62:0] num_q;
  logic [63:0] rem_q;
  logic [47:0] quo_q;
  logic [6:0]  cnt_q;
  logic        busy_q, qsat_q;
  logic [47:0] sum_q;

  // table: energy in the high half, rate in the low half
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_entry) mem_q[load_idx_i[IdxW-1:0]] <= {load_energy_i, load_rate_i};
    if (cmd_i.read_entry) rd_q <= mem_q[entry_i];
  end

  logic [44:0] e_full;
  assign e_full = grid_index_i * step_i;

  logic signed [33:0] d_s;
  assign d_s = $signed({3'b000, e_q}) - $signed({{2{rd_q[63]}}, rd_q[63:32]});

  logic [63:0] sq_lo_p;
  assign sq_lo_p = ad_q[31:0] * ad_q[31:0];
  logic [65:0] pl_lo;
  assign pl_lo = {2'd0, sq_lo_p};
  logic [63:0] pmul;
  assign pmul = sq_q[31:0] * TwoPiQ29;

  // helper sums
  logic [33:0] hi_part;
  assign hi_part = sq_q[65:32];
  logic [65:0] hmul;
  assign hmul = hi_part * TwoPiQ29;
  logic [66:0] r_sum;
  assign r_sum = {hmul[63:0], 3'b000} + {32'd0, pi_q[34:0]};

  logic [61:0] w2;
  assign w2 = width_i * width_i;
  logic [64:0] den_sum;
  assign den_sum = {1'b0, pi_q} + {5'd0, w2[61:2]};

  // numerator bit 63 and the appended zeros feed a zero
  logic [64:0] rem_sh;
  logic        nbit;
  assign nbit   = (cnt_q >= 7'd32 && cnt_q <= 7'd94) ? num_q[cnt_q[5:0] - 6'd32] : 1'b0;
  assign rem_sh = {rem_q, nbit};
  logic        take;
  assign take = rem_sh >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (cmd_i.div_start) begin
      busy_q <= 1'b1;
      cnt_q  <= 7'd95;
    end else if (cmd_i.div_step) begin
      if (cnt_q == '0) busy_q <= 1'b0;
      else cnt_q <= cnt_q - 1'b1;
    end
  end

  assign status_o.div_done = !busy_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.start_grid) begin
      e_q <= (e_full > {14'd0, EnergyMax}) ? EnergyMax : e_full[30:0];
    end
    if (cmd_i.calc_diff) ad_q <= d_s[33] ? 33'(-d_s) : d_s[32:0];
    if (cmd_i.sq_lo) sq_q <= pl_lo;
    // top magnitude bit: add 2^64 and the cross term
    if (cmd_i.sq_hi && ad_q[32]) sq_q <= sq_q + {1'b0, ad_q[31:0], 33'd0} +
                                         {2'b01, 64'd0};
    // low half product, pre-shifted
    if (cmd_i.pi_lo) pi_q <= {29'd0, pmul[63:29]};
    if (cmd_i.pi_hi) begin
      pi_sat_q <= (hmul >= 66'(64'h2000_0000_0000_0000)) || (r_sum[66:64] != '0);
      pi_q     <= r_sum[63:0];
    end
    if (cmd_i.calc_den) begin
      den_q  <= (pi_sat_q || den_sum[64]) ? '1 : den_sum[63:0];
      num_q  <= rd_q[31:0] * width_i;
      rem_q  <= '0;
      quo_q  <= '0;
      qsat_q <= 1'b0;
    end
    if (cmd_i.div_step) begin
      if (rem_sh[64] || take) rem_q <= 64'(rem_sh - {1'b0, den_q});
      else rem_q <= rem_sh[63:0];
      if (quo_q[47]) qsat_q <= 1'b1;
      quo_q <= {quo_q[46:0], rem_sh[64] | take};
    end
  end

  logic [47:0] term;
  assign term = (den_q == '0 || qsat_q) ? DensMax : quo_q;
  logic [48:0] acc;
  assign acc = {1'b0, sum_q} + {1'b0, term};

  always_ff @(posedge clk_i) begin
    if (cmd_i.clear_sum) sum_q <= '0;
    else if (cmd_i.accumulate) sum_q <= acc[48] ? DensMax : acc[47:0];
  end

  assign grid_energy_o = e_q;
  assign density_o     = sum_q;

endmodule

/* sv/lorentzian_density_of_states_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lorentzian_density_of_states_unit
// load state entries, then evaluate the broadened density at grid points
// ----------------------------------------------------------------------------
// A load transaction writes one table entry. An evaluate transaction sums n
// entries: each entry passes seven setup steps (table read, difference, two
// square halves, two 2*pi halves, denominator), then 96 steps of the one
// bit-per-cycle divider, a check that it has finished, and one accumulate
// step; the divider sets the rate. The result waits in an output register;
// the next transaction is taken in the cycle after the result has been
// accepted.
module lorentzian_density_of_states_unit import ldos_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  ldos_cfg_if.sink   cfg,
  ldos_req_if.sink   req,
  ldos_res_if.source res
);

  logic [30:0] width_q;
  logic [24:0] step_q;
  logic [8:0]  count_q;
  dp_cmd_t     cmd;
  dp_status_t  status;
  logic [IdxW-1:0] entry;

  // register writes are always taken
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q <= 31'd167772;
      step_q  <= 25'd1678;
      count_q <= 9'd1;
    end else if (cfg.valid) begin
      case (cfg.index)
        CFG_WIDTH: width_q <= cfg.data[30:0];
        CFG_STEP:  step_q  <= cfg.data[24:0];
        CFG_COUNT: count_q <= cfg.data[8:0];
        default: ;
      endcase
    end
  end

  ldos_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i (req.valid),
    .in_type_i  (req.req_type),
    .in_ready_o (req.ready),
    .count_i    (count_q),
    .entry_o    (entry),
    .out_valid_o(res.valid),
    .out_ready_i(res.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  ldos_dp u_dp (
    .clk_i, .rst_ni,
    .cmd_i        (cmd),
    .status_o     (status),
    .load_idx_i   (req.entry_index),
    .load_energy_i(req.state_energy),
    .load_rate_i  (req.state_rate),
    .grid_index_i (req.grid_index),
    .entry_i      (entry),
    .width_i      (width_q),
    .step_i       (step_q),
    .grid_energy_o(res.grid_energy),
    .density_o    (res.density)
  );

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the lorentzian density of states unit: a directed
// table followed by randomized load/evaluate phases, results scored against expected
// values written into the rows or an exact fixed-point predictor of the broadened density
// ----------------------------------------------------------------------------
module tb_top;
  import ldos_pkg::*;

  localparam int unsigned IdleLimit = 100000;  // cycles without any transaction
  localparam int unsigned SettleCyc = 8;       // settle time after a trailing load

  typedef enum logic {ROW_CFG, ROW_REQ} row_kind_e;
  typedef enum logic {REQ_LOAD = 1'b0, REQ_EVAL = 1'b1} req_kind_e;

  // one grid point result
  typedef struct {
    logic [30:0] energy;
    logic [47:0] density;
  } point_t;

  // one line of the directed table
  typedef struct {
    row_kind_e   kind;
    cfg_idx_e    reg_index;
    logic [31:0] reg_data;
    req_kind_e   op;
    logic [7:0]  entry;
    logic [31:0] energy;
    logic [31:0] rate;
    logic [19:0] grid;
    bit          typed;     // expected result written into the row
    point_t      fixed;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  ldos_cfg_if cfg_ch ();
  ldos_req_if req_ch ();
  ldos_res_if res_ch ();

  lorentzian_density_of_states_unit u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg    (cfg_ch),
    .req    (req_ch),
    .res    (res_ch)
  );

  always #5 clk_i = ~clk_i;

  // shadow of the block's registers and tables
  logic [30:0] width_reg;
  logic [24:0] step_reg;
  logic [8:0]  count_reg;
  logic [31:0] energy_tab [MaxStates];
  logic [31:0] rate_tab [MaxStates];

  point_t pending_points[$];
  row_t   dir_rows[$];
  int     err_cnt = 0;
  bit     quiet = 1'b0;     // phases without any idling
  int     rx_stall = 0;
  int     idle_cyc = 0;

  // exact broadened density at one grid point, with the block's rounding
  function automatic point_t predict_point(input logic [19:0] g);
    point_t           p;
    logic [63:0]      e_full;
    logic [8:0]       n;
    logic signed [33:0] d;
    logic [32:0]      ad;
    logic [63:0]      den, half2, num;
    logic [127:0]     wide;
    logic [47:0]      term;
    logic [48:0]      s;
    e_full = 64'(g) * 64'(step_reg);
    p.energy = (e_full > 64'(EnergyMax)) ? EnergyMax : e_full[30:0];
    n = (count_reg > 9'(MaxStates)) ? 9'(MaxStates) : count_reg;
    p.density = '0;
    for (int k = 0; k < n; k++) begin
      d = $signed({3'b000, p.energy}) - $signed({{2{energy_tab[k][31]}}, energy_tab[k]});
      ad = d[33] ? 33'(-d) : 33'(d);
      // 2*pi*d^2 in Q.48, saturated to 64 bits
      wide = (128'(64'(ad) * 64'(ad)) * 128'(TwoPiQ29)) >> 29;
      den = (wide[127:64] != '0) ? '1 : wide[63:0];
      half2 = (64'(width_reg) * 64'(width_reg)) >> 2;
      wide = 128'(den) + 128'(half2);
      den = wide[64] ? '1 : wide[63:0];
      num = 64'(rate_tab[k]) * 64'(width_reg);
      if (den == '0) begin
        term = DensMax;
      end else begin
        wide = (128'(num) << 32) / 128'(den);
        term = (wide > 128'(DensMax)) ? DensMax : wide[47:0];
      end
      s = 49'(p.density) + 49'(term);
      p.density = s[48] ? DensMax : s[47:0];
    end
    return p;
  endfunction

  // mostly short gaps, a few long ones, none in quiet phases
  function automatic int rand_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic void row_cfg(input cfg_idx_e idx, input logic [31:0] val);
    row_t r;
    r = '{kind: ROW_CFG, reg_index: idx, reg_data: val, op: REQ_LOAD, default: '0};
    dir_rows.push_back(r);
  endfunction

  function automatic void row_load(input logic [7:0] idx, input logic [31:0] en,
                                   input logic [31:0] rate);
    row_t r;
    r = '{kind: ROW_REQ, reg_index: CFG_WIDTH, op: REQ_LOAD, entry: idx, energy: en,
          rate: rate, default: '0};
    dir_rows.push_back(r);
  endfunction

  function automatic void row_eval(input logic [19:0] g, input bit typed,
                                   input logic [30:0] te, input logic [47:0] td);
    row_t r;
    r = '{kind: ROW_REQ, reg_index: CFG_WIDTH, op: REQ_EVAL, grid: g, typed: typed,
          default: '0};
    r.fixed.energy = te;
    r.fixed.density = td;
    dir_rows.push_back(r);
  endfunction

  // one request transaction; the expectation is queued at acceptance
  task automatic drive_req(input req_kind_e op, input logic [7:0] idx,
                           input logic [31:0] en, input logic [31:0] rate,
                           input logic [19:0] g, input bit typed, input point_t fixed);
    int gap;
    gap = rand_gap();
    if (gap > 0) begin
      @(negedge clk_i);
      req_ch.valid = 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    req_ch.valid        = 1'b1;
    req_ch.req_type     = op;
    req_ch.entry_index  = idx;
    req_ch.state_energy = en;
    req_ch.state_rate   = rate;
    req_ch.grid_index   = g;
    do @(posedge clk_i); while (!req_ch.ready);
    if (op == REQ_LOAD) begin
      energy_tab[idx] = en;
      rate_tab[idx] = rate;
    end else begin
      pending_points.push_back(typed ? fixed : predict_point(g));
    end
  endtask

  // block idle: every result in, then the settle time for a trailing load
  task automatic wait_idle();
    @(negedge clk_i);
    req_ch.valid = 1'b0;
    while (pending_points.size() != 0) @(posedge clk_i);
    repeat (SettleCyc) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [31:0] val);
    @(negedge clk_i);
    cfg_ch.valid = 1'b1;
    cfg_ch.index = idx;
    cfg_ch.data  = val;
    do @(posedge clk_i); while (!cfg_ch.ready);
    case (idx)
      CFG_WIDTH: width_reg = val[30:0];
      CFG_STEP:  step_reg  = val[24:0];
      default:   count_reg = val[8:0];
    endcase
    @(negedge clk_i);
    cfg_ch.valid = 1'b0;
  endtask

  task automatic rand_load(input logic [7:0] idx);
    point_t none;
    none = '{default: '0};
    drive_req(REQ_LOAD, idx, $urandom(), $urandom(), 20'($urandom()), 1'b0, none);
  endtask

  task automatic rand_eval();
    point_t none;
    none = '{default: '0};
    drive_req(REQ_EVAL, 8'($urandom()), $urandom(), $urandom(),
              20'($urandom()), 1'b0, none);
  endtask

  // result checker: fields against the oldest expectation
  always @(posedge clk_i) begin
    point_t want;
    if (rst_ni && res_ch.valid && res_ch.ready) begin
      if (pending_points.size() == 0) begin
        $error("result transaction with nothing expected");
        err_cnt++;
      end else begin
        want = pending_points.pop_front();
        if (res_ch.grid_energy !== want.energy) begin
          $error("grid_energy: expected %0d, got %0d", want.energy, res_ch.grid_energy);
          err_cnt++;
        end
        if (res_ch.density !== want.density) begin
          $error("density: expected %0d, got %0d", want.density, res_ch.density);
          err_cnt++;
        end
      end
    end
  end

  // receiver back-pressure
  always @(negedge clk_i) begin
    if (rx_stall > 0) begin
      res_ch.ready = 1'b0;
      rx_stall--;
    end else begin
      res_ch.ready = 1'b1;
      if (!quiet && $urandom_range(0, 7) == 0)
        rx_stall = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(1, 3);
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk_i) begin
    if ((req_ch.valid && req_ch.ready) || (cfg_ch.valid && cfg_ch.ready) ||
        (res_ch.valid && res_ch.ready)) begin
      idle_cyc = 0;
    end else begin
      idle_cyc++;
      if (idle_cyc >= IdleLimit) begin
        $display("tb_top: errors");
        $finish;
      end
    end
  end

  initial begin
    int n;
    int items;
    row_t r;
    req_ch.valid = 1'b0;
    req_ch.req_type = REQ_LOAD;
    req_ch.entry_index = '0;
    req_ch.state_energy = '0;
    req_ch.state_rate = '0;
    req_ch.grid_index = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = CFG_WIDTH;
    cfg_ch.data = '0;
    res_ch.ready = 1'b1;
    width_reg = 31'd167772;
    step_reg  = 25'd1678;
    count_reg = 9'd1;

    // directed table: reset values first, then the corners
    row_load(8'd0, 32'd0, 32'h0001_0000);
    row_eval(20'd0, 1'b0, '0, '0);
    row_eval(20'd100, 1'b0, '0, '0);
    row_load(8'd255, 32'h8000_0000, 32'hFFFF_FFFF);
    row_load(8'd0, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
    row_eval(20'hFFFFF, 1'b0, '0, '0);
    row_eval(20'd0, 1'b0, '0, '0);
    row_load(8'd0, 32'h8000_0000, 32'hFFFF_FFFF);
    row_eval(20'hFFFFF, 1'b0, '0, '0);
    // zero width and zero distance: denominator vanishes, density saturates
    row_cfg(CFG_WIDTH, 32'd0);
    row_cfg(CFG_STEP, 32'd0);
    row_load(8'd0, 32'd0, 32'h0001_2345);
    row_eval(20'd777, 1'b1, 31'd0, DensMax);
    // nothing summed
    row_cfg(CFG_COUNT, 32'd0);
    row_eval(20'hFFFFF, 1'b1, 31'd0, 48'd0);
    // grid energy saturates at the largest grid index with a step of 2^24
    row_cfg(CFG_STEP, 32'h0100_0000);
    row_cfg(CFG_WIDTH, 32'h7FFF_FFFF);
    row_cfg(CFG_COUNT, 32'd1);
    row_eval(20'hFFFFF, 1'b1, EnergyMax, predict_point(20'hFFFFF).density);
    row_eval(20'd1, 1'b0, '0, '0);
    row_load(8'd1, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
    row_cfg(CFG_COUNT, 32'd2);
    row_eval(20'd3, 1'b0, '0, '0);
    row_eval(20'd0, 1'b0, '0, '0);

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (dir_rows[i]) begin
      r = dir_rows[i];
      if (r.kind == ROW_CFG) begin
        wait_idle();
        write_reg(r.reg_index, r.reg_data);
      end else begin
        // typed density of the saturation row depends on the width at run time
        if (r.typed && r.fixed.energy == EnergyMax) r.fixed = predict_point(r.grid);
        drive_req(r.op, r.entry, r.energy, r.rate, r.grid, r.typed, r.fixed);
      end
    end

    // random phases: fresh settings, the summed entries loaded, then a mix
    for (int ph = 0; ph < 6; ph++) begin
      wait_idle();
      quiet = (ph % 4 == 2);
      case ($urandom_range(0, 3))
        0:       write_reg(CFG_WIDTH, 32'd0);
        1:       write_reg(CFG_WIDTH, 32'h7FFF_FFFF);
        default: write_reg(CFG_WIDTH, $urandom() & 32'h7FFF_FFFF);
      endcase
      case ($urandom_range(0, 3))
        0:       write_reg(CFG_STEP, 32'd1);
        1:       write_reg(CFG_STEP, 32'h0100_0000);
        default: write_reg(CFG_STEP, $urandom_range(0, 32'h0100_0000));
      endcase
      write_reg(CFG_COUNT, $urandom_range(0, 6));
      n = count_reg;
      for (int k = 0; k < n; k++) rand_load(8'(k));
      items = $urandom_range(8, 14);
      for (int i = 0; i < items; i++) begin
        // sender holds off until the block has drained
        if (ph == 3 && i == items / 2) wait_idle();
        if ($urandom_range(0, 9) < 6) rand_eval();
        else rand_load(8'($urandom()));
      end
    end

    wait_idle();
    repeat (20) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule

/* files.f */
sv/ldos_pkg.sv
sv/ldos_if.sv
sv/ldos_ctrl.sv
sv/ldos_dp.sv
sv/lorentzian_density_of_states_unit.sv
tb/tb_top.sv
